FILE: design/pid_with_antiwindup_core_defines.svh
// Assertion macros shared by the PID core modules.
`ifndef PID_WITH_ANTIWINDUP_CORE_DEFINES_SVH
`define PID_WITH_ANTIWINDUP_CORE_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define PIDAW_ASSERT(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("pid_with_antiwindup_core: check failed");

// The consequent must hold in the same cycle as the antecedent.
`define PIDAW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pid_with_antiwindup_core: implication failed");

// The consequent must hold in the cycle after the antecedent.
`define PIDAW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pid_with_antiwindup_core: next-cycle check failed");

`endif

FILE: design/pidaw_pkg.sv
// Shared types and constants for the PID core with anti-windup.
`timescale 1ns / 1ps

package pidaw_pkg;

  // Width of the internal terms: products, integral term and sum.
  localparam int ACC_WIDTH = 48;

  // Width of the configuration register index.
  localparam int CFG_INDEX_WIDTH = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_KD     = 3'd2,
    REG_LO_LIM = 3'd3,
    REG_HI_LIM = 3'd4
  } cfg_reg_t;

  // Clamp status codes of a result item.
  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_HIGH = 2'd1,
    CLAMP_LOW  = 2'd2
  } clamp_t;

  // Control that travels with an item from one pipeline stage to the next.
  typedef struct packed {
    logic vld;
    logic clr;
  } stage_ctl_t;

endpackage

FILE: design/pidaw_cfg_regs.sv
// Configuration registers: gains and output limits.
`timescale 1ns / 1ps

module pidaw_cfg_regs #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr,
  input  logic [pidaw_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]                cfg_data,
  output logic signed [DATA_WIDTH-1:0]         kp,
  output logic signed [DATA_WIDTH-1:0]         ki,
  output logic signed [DATA_WIDTH-1:0]         kd,
  output logic signed [DATA_WIDTH-1:0]         lo_lim,
  output logic signed [DATA_WIDTH-1:0]         hi_lim
);
  import pidaw_pkg::*;

  // The value 1.0 in the data format; it vanishes when the fraction is too wide.
  localparam logic [DATA_WIDTH-1:0] ONE_Q = DATA_WIDTH'(64'd1 << FRACTION_BITS);

  logic [DATA_WIDTH-1:0] kp_r, ki_r, kd_r, lo_lim_r, hi_lim_r;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= ONE_Q;
      ki_r     <= '0;
      kd_r     <= '0;
      lo_lim_r <= '0;
      hi_lim_r <= ONE_Q;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_index))
        REG_KP:     kp_r     <= cfg_data;
        REG_KI:     ki_r     <= cfg_data;
        REG_KD:     kd_r     <= cfg_data;
        REG_LO_LIM: lo_lim_r <= cfg_data;
        REG_HI_LIM: hi_lim_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign kp     = $signed(kp_r);
  assign ki     = $signed(ki_r);
  assign kd     = $signed(kd_r);
  assign lo_lim = $signed(lo_lim_r);
  assign hi_lim = $signed(hi_lim_r);

endmodule

FILE: design/pidaw_in_stage.sv
// Input register stage: captures the error sample and forms the difference.
`timescale 1ns / 1ps

module pidaw_in_stage #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [DATA_WIDTH-1:0]  in_error_sample,
  input  logic                          in_clear,
  input  logic                          ready_dn,
  output pidaw_pkg::stage_ctl_t         ctl_o,
  output logic signed [DATA_WIDTH-1:0]  err_o,
  output logic signed [DATA_WIDTH:0]    diff_o
);
  import pidaw_pkg::*;

  stage_ctl_t                  ctl_r;
  logic signed [DATA_WIDTH-1:0] err_r;
  logic signed [DATA_WIDTH:0]   diff_r;
  logic signed [DATA_WIDTH:0]   diff_nxt;
  logic                         have_prev_r;
  logic                         ready_up;
  logic                         load;

  // The stage takes an item when it is empty or its item moves on.
  assign ready_up = !ctl_r.vld || ready_dn;
  assign in_stall = !ready_up;
  assign load     = in_valid && ready_up;

  // The last captured sample is the previous error; a clear drops it.
  always_comb begin
    if (have_prev_r && !in_clear) begin
      diff_nxt = $signed({in_error_sample[DATA_WIDTH-1], in_error_sample})
               - $signed({err_r[DATA_WIDTH-1], err_r});
    end else begin
      diff_nxt = '0;
    end
  end

  // Control and history flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= '0;
      have_prev_r <= 1'b0;
    end else begin
      if (ready_up) begin
        ctl_r.vld <= in_valid;
        ctl_r.clr <= in_clear;
      end
      if (load) begin
        have_prev_r <= 1'b1;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load) begin
      err_r  <= in_error_sample;
      diff_r <= diff_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign err_o  = err_r;
  assign diff_o = diff_r;

endmodule

FILE: design/pidaw_mul_stage.sv
// Product stage: the three gain products, scaled and saturated.
`timescale 1ns / 1ps

module pidaw_mul_stage #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  pidaw_pkg::stage_ctl_t                     ctl_i,
  input  logic signed [DATA_WIDTH-1:0]              err_i,
  input  logic signed [DATA_WIDTH:0]                diff_i,
  input  logic signed [DATA_WIDTH-1:0]              kp,
  input  logic signed [DATA_WIDTH-1:0]              ki,
  input  logic signed [DATA_WIDTH-1:0]              kd,
  input  logic                                      ready_dn,
  output logic                                      ready_up,
  output pidaw_pkg::stage_ctl_t                     ctl_o,
  output logic signed [pidaw_pkg::ACC_WIDTH-1:0]    p_o,
  output logic signed [pidaw_pkg::ACC_WIDTH-1:0]    ie_o,
  output logic signed [pidaw_pkg::ACC_WIDTH-1:0]    d_o
);
  import pidaw_pkg::*;

  // Full product width, and a working width that also holds the saturation bounds.
  localparam int PW = 2 * DATA_WIDTH + 1;
  localparam int EW = (PW > ACC_WIDTH + FRACTION_BITS) ? PW : ACC_WIDTH + FRACTION_BITS;
  localparam logic signed [EW-1:0] ACC_MAX_E = EW'({1'b0, {(ACC_WIDTH-1){1'b1}}});
  localparam logic signed [EW-1:0] ACC_MIN_E = ~ACC_MAX_E;

  // Product shifted right by the fraction bits (toward minus infinity), saturated.
  function automatic logic signed [ACC_WIDTH-1:0] mul_q(
    input logic signed [DATA_WIDTH-1:0] a,
    input logic signed [DATA_WIDTH:0]   b
  );
    logic signed [PW-1:0] prod;
    logic signed [EW-1:0] quo;
    prod = PW'(a) * PW'(b);
    quo  = EW'(prod) >>> FRACTION_BITS;
    if (quo > ACC_MAX_E) begin
      mul_q = ACC_MAX_E[ACC_WIDTH-1:0];
    end else if (quo < ACC_MIN_E) begin
      mul_q = ACC_MIN_E[ACC_WIDTH-1:0];
    end else begin
      mul_q = quo[ACC_WIDTH-1:0];
    end
  endfunction

  stage_ctl_t                  ctl_r;
  logic signed [ACC_WIDTH-1:0] p_r, ie_r, d_r;
  logic signed [ACC_WIDTH-1:0] p_nxt, ie_nxt, d_nxt;

  assign ready_up = !ctl_r.vld || ready_dn;

  // Three independent multipliers.
  always_comb begin
    p_nxt  = mul_q(kp, $signed({err_i[DATA_WIDTH-1], err_i}));
    ie_nxt = mul_q(ki, $signed({err_i[DATA_WIDTH-1], err_i}));
    d_nxt  = mul_q(kd, diff_i);
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (ready_up) begin
      ctl_r <= ctl_i;
    end
  end

  // Products.
  always_ff @(posedge clk) begin
    if (ready_up && ctl_i.vld) begin
      p_r  <= p_nxt;
      ie_r <= ie_nxt;
      d_r  <= d_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign p_o   = p_r;
  assign ie_o  = ie_r;
  assign d_o   = d_r;

endmodule

FILE: design/pidaw_acc_stage.sv
// Result stage: integral update, sum, clamp and back-calculation.
`timescale 1ns / 1ps
`include "pid_with_antiwindup_core_defines.svh"

module pidaw_acc_stage #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  pidaw_pkg::stage_ctl_t                   ctl_i,
  input  logic signed [pidaw_pkg::ACC_WIDTH-1:0]  p_i,
  input  logic signed [pidaw_pkg::ACC_WIDTH-1:0]  ie_i,
  input  logic signed [pidaw_pkg::ACC_WIDTH-1:0]  d_i,
  input  logic signed [DATA_WIDTH-1:0]            ki,
  input  logic signed [DATA_WIDTH-1:0]            lo_lim,
  input  logic signed [DATA_WIDTH-1:0]            hi_lim,
  output logic                                    ready_up,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [DATA_WIDTH-1:0]            out_drive,
  output logic [1:0]                              out_clamp_status
);
  import pidaw_pkg::*;

  localparam int AW = ACC_WIDTH;
  localparam logic signed [AW+1:0] ACC_MAX_W = (AW+2)'({1'b0, {(AW-1){1'b1}}});
  localparam logic signed [AW+1:0] ACC_MIN_W = ~ACC_MAX_W;

  // Saturate a sum of a few internal terms to the internal width.
  function automatic logic signed [AW-1:0] sat_acc(input logic signed [AW+1:0] x);
    if (x > ACC_MAX_W) begin
      sat_acc = ACC_MAX_W[AW-1:0];
    end else if (x < ACC_MIN_W) begin
      sat_acc = ACC_MIN_W[AW-1:0];
    end else begin
      sat_acc = x[AW-1:0];
    end
  endfunction

  logic                         out_vld_r;
  logic signed [DATA_WIDTH-1:0] drive_r, drive_nxt;
  clamp_t                       status_r, status_nxt;
  logic signed [AW-1:0]         integ_r, integ_nxt;
  logic signed [AW-1:0]         integ_base, integ_acc, sum_sat, clamp_term;
  logic signed [AW-1:0]         lo_ext, hi_ext, lim_sel;
  logic                         load;
  logic                         res_high, res_low, res_none, ki_idle_load;

  // The result register takes an item when empty or when its item is taken.
  assign ready_up = !out_vld_r || !out_stall;
  assign load     = ctl_i.vld && ready_up;

  // Integral accumulation, total sum and clamp against the limits.
  always_comb begin
    integ_base = ctl_i.clr ? '0 : integ_r;
    integ_acc  = sat_acc((AW+2)'(integ_base) + (AW+2)'(ie_i));
    sum_sat    = sat_acc((AW+2)'(p_i) + (AW+2)'(integ_acc) + (AW+2)'(d_i));
    lo_ext     = AW'(lo_lim);
    hi_ext     = AW'(hi_lim);
    if (sum_sat > hi_ext) begin
      status_nxt = CLAMP_HIGH;
      lim_sel    = hi_ext;
      drive_nxt  = hi_lim;
    end else if (sum_sat < lo_ext) begin
      status_nxt = CLAMP_LOW;
      lim_sel    = lo_ext;
      drive_nxt  = lo_lim;
    end else begin
      status_nxt = CLAMP_NONE;
      lim_sel    = sum_sat;
      drive_nxt  = sum_sat[DATA_WIDTH-1:0];
    end
    // Back-calculation: the integral term makes the unclamped sum hit the limit.
    clamp_term = sat_acc((AW+2)'(lim_sel) - (AW+2)'(p_i) - (AW+2)'(d_i));
    if (status_nxt != CLAMP_NONE && ki != '0) begin
      integ_nxt = clamp_term;
    end else begin
      integ_nxt = integ_acc;
    end
  end

  // Output valid and integral state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      integ_r   <= '0;
    end else if (load) begin
      out_vld_r <= 1'b1;
      integ_r   <= integ_nxt;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      drive_r  <= drive_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_drive        = drive_r;
  assign out_clamp_status = status_r;

  // Conditions watched by the checks below.
  assign res_high     = out_vld_r && status_r == CLAMP_HIGH;
  assign res_low      = out_vld_r && status_r == CLAMP_LOW;
  assign res_none     = out_vld_r && status_r == CLAMP_NONE;
  assign ki_idle_load = load && ki == '0 && !ctl_i.clr;

  // A clamped result carries its limit, an unclamped one lies between the limits.
  `PIDAW_ASSERT_IMPL(a_clamp_high, clk, rst_n, res_high, drive_r == hi_lim)
  `PIDAW_ASSERT_IMPL(a_clamp_low, clk, rst_n, res_low, drive_r == lo_lim)
  `PIDAW_ASSERT_IMPL(a_in_range, clk, rst_n, res_none, drive_r >= lo_lim && drive_r <= hi_lim)
  // With zero integral gain the integral term only changes through a clear.
  `PIDAW_ASSERT_NEXT(a_zero_ki_hold, clk, rst_n, ki_idle_load, integ_r == $past(integ_r))

endmodule

FILE: design/pid_with_antiwindup_core.sv
// PID controller with back-calculation anti-windup, top level.
//
// Usage: one error sample and a clear flag enter per item on the in_ channel;
// each item gives exactly one result item (drive value and clamp status) on
// the out_ channel. Values are signed fixed point with FRACTION_BITS fraction
// bits. Both channels move an item at a rising edge where valid is high and
// stall is low. Gains and limits are written on the cfg_ channel; cfg_ready is
// high only while no item is inside the pipeline.
// Pipeline: input register, product register, result register; out_valid
// rises when an item reaches the result register, and the result is taken
// at a rising edge where out_stall is low.
// Throughput: one item per cycle while out_stall is low; the limit is the
// integral term, which goes through add, clamp and back-calculation per item.
// Stall: when out_stall holds a result, the stages behind it keep filling until
// each holds an item, then in_stall rises in the same cycle.
// Reset (rst_n low, synchronous): the pipeline empties, the integral term and
// the error history clear, gains return to Kp = 1.0, Ki = Kd = 0 and limits
// to [0, 1.0].
`timescale 1ns / 1ps

module pid_with_antiwindup_core #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [DATA_WIDTH-1:0]          in_error_sample,
  input  logic                                  in_clear,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [DATA_WIDTH-1:0]          out_drive,
  output logic [1:0]                            out_clamp_status,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pidaw_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]                 cfg_data
);
  import pidaw_pkg::*;

  logic signed [DATA_WIDTH-1:0] kp, ki, kd, lo_lim, hi_lim;
  stage_ctl_t                   ctl_in, ctl_mul;
  logic signed [DATA_WIDTH-1:0] err;
  logic signed [DATA_WIDTH:0]   diff;
  logic signed [ACC_WIDTH-1:0]  p_term, ie_term, d_term;
  logic                         ready_mul, ready_acc;

  // Configuration is taken only while the pipeline is empty.
  assign cfg_ready = !(ctl_in.vld || ctl_mul.vld || out_valid);

  pidaw_cfg_regs #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .kp        (kp),
    .ki        (ki),
    .kd        (kd),
    .lo_lim    (lo_lim),
    .hi_lim    (hi_lim)
  );

  pidaw_in_stage #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_in (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_error_sample (in_error_sample),
    .in_clear        (in_clear),
    .ready_dn        (ready_mul),
    .ctl_o           (ctl_in),
    .err_o           (err),
    .diff_o          (diff)
  );

  pidaw_mul_stage #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (ctl_in),
    .err_i    (err),
    .diff_i   (diff),
    .kp       (kp),
    .ki       (ki),
    .kd       (kd),
    .ready_dn (ready_acc),
    .ready_up (ready_mul),
    .ctl_o    (ctl_mul),
    .p_o      (p_term),
    .ie_o     (ie_term),
    .d_o      (d_term)
  );

  pidaw_acc_stage #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_acc (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl_i            (ctl_mul),
    .p_i              (p_term),
    .ie_i             (ie_term),
    .d_i              (d_term),
    .ki               (ki),
    .lo_lim           (lo_lim),
    .hi_lim           (hi_lim),
    .ready_up         (ready_acc),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_drive        (out_drive),
    .out_clamp_status (out_clamp_status)
  );

endmodule
